/* hw/rtl/fuzzy_gain_pid_controller_unit_macros.svh */
// Assertion helpers used by the top-level RTL of the fuzzy-gain PID controller.
`ifndef FUZZY_GAIN_PID_CONTROLLER_UNIT_MACROS_SVH
`define FUZZY_GAIN_PID_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FGPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FGPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/fgpc_pkg.sv */
package fgpc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CFG_W     = 31;
   localparam int DATA_W    = 32;
   localparam int CHG_W     = 33;
   localparam int SUM_W     = 48;
   localparam int DRIVE_W   = 26;
   localparam int IDX_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int MAG_W     = CFG_W + 2;
   localparam int PROD_W    = CFG_W + SUM_W;
   localparam int MUL_STEPS = SUM_W;

   localparam logic [CSR_IDX_W-1:0] REG_ERROR_MAX        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_CHANGE_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KP_WEIGHT        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KI_WEIGHT        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KD_WEIGHT        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KP_BASE          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KI_BASE          = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_KD_BASE          = 3'd7;

   localparam logic [CFG_W-1:0] RST_ERROR_MAX        = 31'd3276800;
   localparam logic [CFG_W-1:0] RST_ERROR_CHANGE_MAX = 31'd327680;
   localparam logic [CFG_W-1:0] RST_KP_WEIGHT        = 31'd327680;
   localparam logic [CFG_W-1:0] RST_KI_WEIGHT        = 31'd6554;
   localparam logic [CFG_W-1:0] RST_KD_WEIGHT        = 31'd655360;

   localparam logic [IDX_W-1:0] IDX_LOW  = 3'd0;
   localparam logic [IDX_W-1:0] IDX_MID  = 3'd3;
   localparam logic [IDX_W-1:0] IDX_HIGH = 3'd6;

   localparam logic [DRIVE_W-1:0] DRIVE_LO = DRIVE_W'(1 << FRAC_BITS);
   localparam logic [DRIVE_W-1:0] DRIVE_HI = DRIVE_W'(1000 << FRAC_BITS);

   typedef logic signed [2:0] delta_type;

   localparam delta_type TAB_P [7][7] = '{
      '{ 3,  3,  2,  2,  1,  0,  0},
      '{ 3,  3,  2,  1,  1,  0, -1},
      '{ 2,  2,  2,  1,  0, -1, -1},
      '{ 2,  2,  1,  0, -1, -2, -2},
      '{ 1,  1,  0, -1, -1, -2, -2},
      '{ 1,  0, -1, -2, -2, -3, -3},
      '{ 0,  0, -1, -2, -2, -3, -3}
   };
   localparam delta_type TAB_I [7][7] = '{
      '{-3, -3, -2, -2, -1,  0,  0},
      '{-3, -3, -2, -1, -1,  0,  0},
      '{-3, -2, -1, -1,  0,  1,  1},
      '{-2, -2, -1,  0,  1,  2,  2},
      '{-2, -1,  0,  1,  1,  2,  3},
      '{ 0,  0,  1,  1,  2,  3,  3},
      '{ 0,  0,  1,  2,  2,  3,  3}
   };
   localparam delta_type TAB_D [7][7] = '{
      '{ 1, -1, -3, -3, -3, -2,  1},
      '{ 1, -1, -3, -2, -2, -1,  0},
      '{ 0, -1, -2, -2, -1, -1,  0},
      '{ 0, -1, -2, -1, -1, -1,  0},
      '{ 0,  0,  0,  0,  0,  0,  0},
      '{ 3,  1,  0,  0,  0,  0,  0},
      '{ 3,  2,  1,  1,  1,  1,  1}
   };

   // Magnitude of delta times weight, built from shifts and one add.
   function automatic logic [MAG_W-1:0] mag_calc(delta_type d, logic [CFG_W-1:0] w);
      logic [1:0] a;
      a = d[2] ? 2'(-d) : 2'(d);
      case (a)
         2'd0:    return '0;
         2'd1:    return {2'b00, w};
         2'd2:    return {1'b0, w, 1'b0};
         default: return {2'b00, w} + {1'b0, w, 1'b0};
      endcase
   endfunction

   // Base plus or minus the magnitude, limited to 0 .. 2^31-1.
   function automatic logic [CFG_W-1:0] gain_sat(logic [CFG_W-1:0] base, logic neg,
                                                 logic [MAG_W-1:0] mag);
      logic signed [MAG_W+1:0] g;
      g = neg ? $signed({3'b000, base}) - $signed({2'b00, mag})
              : $signed({3'b000, base}) + $signed({2'b00, mag});
      if (g < 0) return '0;
      if (g > $signed({3'b000, {CFG_W{1'b1}}})) return {CFG_W{1'b1}};
      return g[CFG_W-1:0];
   endfunction

endpackage

/* hw/rtl/fgpc_index.sv */
module fgpc_index (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [fgpc_pkg::CHG_W-1:0]   x,
   input  logic        [fgpc_pkg::CFG_W-1:0]   mx,
   output logic                                done,
   output logic        [fgpc_pkg::IDX_W-1:0]   index
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_LOOP = 2'd3;

   localparam int N_W = fgpc_pkg::CHG_W + 4;

   logic [1:0]                          state_ff, state_in;
   logic signed [fgpc_pkg::CHG_W-1:0]   x_ff, x_in;
   logic [fgpc_pkg::CFG_W-1:0]          mx_ff, mx_in;
   logic signed [N_W-2:0]               six_ff, six_in;
   logic [fgpc_pkg::CFG_W+3:0]          seven_ff, seven_in;
   logic signed [N_W-1:0]               r_ff, r_in;
   logic [fgpc_pkg::IDX_W-1:0]          q_ff, q_in;
   logic                                done_ff, done_in;
   logic signed [N_W-2:0]               xs;
   logic [N_W-1:0]                      dv;

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      mx_in    = mx_ff;
      six_in   = six_ff;
      seven_in = seven_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      xs       = {{3{x_ff[fgpc_pkg::CHG_W-1]}}, x_ff};
      dv       = {5'b00000, mx_ff, 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               x_in     = x;
               mx_in    = mx;
               q_in     = fgpc_pkg::IDX_LOW;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            six_in   = (xs <<< 2) + (xs <<< 1);
            seven_in = {mx_ff, 3'b000} - {4'b0000, mx_ff};
            state_in = ST_ADD;
         end
         ST_ADD: begin
            r_in     = {six_ff[N_W-2], six_ff} + $signed({1'b0, seven_ff});
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (mx_ff == '0) begin
               q_in = x_ff[fgpc_pkg::CHG_W-1] ? fgpc_pkg::IDX_LOW :
                      (x_ff != '0) ? fgpc_pkg::IDX_HIGH : fgpc_pkg::IDX_MID;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (r_ff[N_W-1]) begin
               q_in     = fgpc_pkg::IDX_LOW;
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (q_ff == fgpc_pkg::IDX_HIGH || unsigned'(r_ff) < dv) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               r_in = r_ff - $signed(dv);
               q_in = q_ff + 3'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff     <= x_in;
      mx_ff    <= mx_in;
      six_ff   <= six_in;
      seven_ff <= seven_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
   end

   assign done  = done_ff;
   assign index = q_ff;

endmodule

/* hw/rtl/fgpc_mul.sv */
module fgpc_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic        [fgpc_pkg::CFG_W-1:0]    gain,
   input  logic signed [fgpc_pkg::SUM_W-1:0]    value,
   output logic                                 done,
   output logic signed [fgpc_pkg::DATA_W-1:0]   result
);

   localparam int CNT_W = $clog2(fgpc_pkg::MUL_STEPS);
   localparam int PW    = fgpc_pkg::PROD_W;
   localparam int SW    = fgpc_pkg::SUM_W;
   localparam int GW    = fgpc_pkg::CFG_W;
   localparam int FB    = fgpc_pkg::FRAC_BITS;
   localparam int DW    = fgpc_pkg::DATA_W;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [GW-1:0]        g_ff, g_in;
   logic [SW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic signed [DW-1:0] res_ff, res_in;
   logic [GW:0]          top_sum;
   logic [DW-1:0]        q_rnd;

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      g_in    = g_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      top_sum = {1'b0, acc_ff[PW-1:SW]} + (mag_ff[0] ? {1'b0, g_ff} : '0);
      q_rnd   = {1'b0, acc_ff[FB+DW-2:FB]} + DW'(acc_ff[FB-1:0] != '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         g_in    = gain;
         neg_in  = value[SW-1];
         mag_in  = value[SW-1] ? SW'(-value) : SW'(value);
         acc_in  = '0;
      end else if (busy_ff) begin
         // One multiplier bit per cycle: add at the top, shift right.
         acc_in = {top_sum, acc_ff[SW-1:1]};
         mag_in = mag_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(fgpc_pkg::MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      if (fin_ff) begin
         done_in = 1'b1;
         if (acc_ff[PW-1:FB+DW-1] != '0) begin
            res_in = neg_ff ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         end else if (neg_ff) begin
            res_in = $signed(-q_rnd);
         end else begin
            res_in = $signed({1'b0, acc_ff[FB+DW-2:FB]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      g_ff   <= g_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

/* hw/rtl/fuzzy_gain_pid_controller_unit.sv */
// From request acceptance to result valid, a request passes through two fuzzy index
// searches, one after the other, and then the bit-serial multipliers.
// Throughput: one request at a time, so the next request is taken only once the result
// is in the result register; the pace is set by the 48-step shift-and-add multipliers and
// the serial subtract loop of the index unit; a result that is not taken holds the next request in its final stage.
// Reset (synchronous, active high) restores the register defaults and clears the
// previous error and the error sum.
module fuzzy_gain_pid_controller_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [fgpc_pkg::DATA_W-1:0]    req_target,
   input  logic signed [fgpc_pkg::DATA_W-1:0]    req_measured,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [fgpc_pkg::DRIVE_W-1:0]   rsp_drive,
   output logic signed [fgpc_pkg::DATA_W-1:0]    rsp_p_term,
   output logic signed [fgpc_pkg::DATA_W-1:0]    rsp_i_term,
   output logic signed [fgpc_pkg::DATA_W-1:0]    rsp_d_term,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [fgpc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [fgpc_pkg::DATA_W-1:0]    csr_wdata
);

`include "fuzzy_gain_pid_controller_unit_macros.svh"

   localparam int DW = fgpc_pkg::DATA_W;
   localparam int CW = fgpc_pkg::CHG_W;
   localparam int SW = fgpc_pkg::SUM_W;
   localparam int GW = fgpc_pkg::CFG_W;

   // Sequencer codes.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ERR   = 4'd1;
   localparam logic [3:0] S_CHG   = 4'd2;
   localparam logic [3:0] S_IDXE  = 4'd3;
   localparam logic [3:0] S_IDXC  = 4'd4;
   localparam logic [3:0] S_GAIN1 = 4'd5;
   localparam logic [3:0] S_GAIN2 = 4'd6;
   localparam logic [3:0] S_MST   = 4'd7;
   localparam logic [3:0] S_MUL   = 4'd8;
   localparam logic [3:0] S_SUM   = 4'd9;

   logic [3:0] state_ff, state_in;

   // Configuration registers.
   logic [GW-1:0] cfg_ff [8];

   // Controller state and working registers.
   logic signed [DW-1:0]  t_ff, t_in, m_ff, m_in;
   logic signed [DW-1:0]  err_ff, err_in, last_err_ff, last_err_in;
   logic signed [CW-1:0]  chg_ff, chg_in;
   logic signed [SW-1:0]  esum_ff, esum_in;
   logic [fgpc_pkg::IDX_W-1:0] ei_ff, ei_in, ci_ff, ci_in;
   logic [fgpc_pkg::MAG_W-1:0] mag_ff [3];
   logic [fgpc_pkg::MAG_W-1:0] mag_in [3];
   logic [2:0]            neg_ff, neg_in;
   logic [GW-1:0]         gain_ff [3];
   logic [GW-1:0]         gain_in [3];

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [fgpc_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic signed [DW-1:0]  p_ff, p_in, i_ff, i_in, d_ff, d_in;

   // Index unit and multipliers.
   logic                  idx_start, idx_done;
   logic signed [CW-1:0]  idx_x;
   logic [GW-1:0]         idx_mx;
   logic [fgpc_pkg::IDX_W-1:0] idx_q;
   logic                  mul_start;
   logic [2:0]            mul_done;
   logic signed [DW-1:0]  mul_res [3];
   logic signed [SW-1:0]  mul_val [3];

   logic signed [DW:0]    diff;
   logic signed [SW:0]    sum_wide;
   logic signed [DW+1:0]  total;
   fgpc_pkg::delta_type   dl [3];

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // The index unit first sees the error, then the change of error.
   assign idx_start = (state_ff == S_CHG) || (state_ff == S_IDXE && idx_done);
   assign idx_x     = (state_ff == S_CHG) ? CW'(err_ff) : chg_ff;
   assign idx_mx    = (state_ff == S_CHG) ? cfg_ff[fgpc_pkg::REG_ERROR_MAX]
                                          : cfg_ff[fgpc_pkg::REG_ERROR_CHANGE_MAX];

   fgpc_index u_index (
      .clock (clock),
      .reset (reset),
      .start (idx_start),
      .x     (idx_x),
      .mx    (idx_mx),
      .done  (idx_done),
      .index (idx_q)
   );

   assign mul_start  = (state_ff == S_MST);
   assign mul_val[0] = SW'(err_ff);
   assign mul_val[1] = esum_ff;
   assign mul_val[2] = SW'(chg_ff);

   for (genvar k = 0; k < 3; k++) begin : g_mul
      fgpc_mul u_mul (
         .clock  (clock),
         .reset  (reset),
         .start  (mul_start),
         .gain   (gain_ff[k]),
         .value  (mul_val[k]),
         .done   (mul_done[k]),
         .result (mul_res[k])
      );
   end

   always_comb begin
      state_in     = state_ff;
      t_in         = t_ff;
      m_in         = m_ff;
      err_in       = err_ff;
      last_err_in  = last_err_ff;
      chg_in       = chg_ff;
      esum_in      = esum_ff;
      ei_in        = ei_ff;
      ci_in        = ci_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      gain_in      = gain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      drive_in     = drive_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      d_in         = d_ff;
      diff         = {t_ff[DW-1], t_ff} - {m_ff[DW-1], m_ff};
      sum_wide     = {esum_ff[SW-1], esum_ff} + (SW+1)'(err_ff);
      // The multipliers hold their products until they finish the next product.
      total        = (DW+2)'(mul_res[0]) + (DW+2)'(mul_res[1]) + (DW+2)'(mul_res[2]);
      dl[0]        = fgpc_pkg::TAB_P[ei_ff][ci_ff];
      dl[1]        = fgpc_pkg::TAB_I[ei_ff][ci_ff];
      dl[2]        = fgpc_pkg::TAB_D[ei_ff][ci_ff];
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               t_in     = req_target;
               m_in     = req_measured;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            // The error saturates to 32-bit signed.
            if (diff[DW] != diff[DW-1]) begin
               err_in = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            end else begin
               err_in = diff[DW-1:0];
            end
            state_in = S_CHG;
         end
         S_CHG: begin
            // The change is kept exactly; the sum saturates at 48 bits.
            chg_in      = CW'(err_ff) - CW'(last_err_ff);
            last_err_in = err_ff;
            if (sum_wide[SW] != sum_wide[SW-1]) begin
               esum_in = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end else begin
               esum_in = sum_wide[SW-1:0];
            end
            state_in = S_IDXE;
         end
         S_IDXE: begin
            if (idx_done) begin
               ei_in    = idx_q;
               state_in = S_IDXC;
            end
         end
         S_IDXC: begin
            if (idx_done) begin
               ci_in    = idx_q;
               state_in = S_GAIN1;
            end
         end
         S_GAIN1: begin
            for (int k = 0; k < 3; k++) begin
               mag_in[k] = fgpc_pkg::mag_calc(dl[k], cfg_ff[fgpc_pkg::REG_KP_WEIGHT + 3'(k)]);
               neg_in[k] = dl[k][2];
            end
            state_in = S_GAIN2;
         end
         S_GAIN2: begin
            for (int k = 0; k < 3; k++) begin
               gain_in[k] = fgpc_pkg::gain_sat(cfg_ff[fgpc_pkg::REG_KP_BASE + 3'(k)],
                                               neg_ff[k], mag_ff[k]);
            end
            state_in = S_MST;
         end
         S_MST: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_done[0]) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            // Hand over only once the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               if (total > $signed({8'b0, fgpc_pkg::DRIVE_HI})) begin
                  drive_in = fgpc_pkg::DRIVE_HI;
               end else if (total < $signed({8'b0, fgpc_pkg::DRIVE_LO})) begin
                  drive_in = fgpc_pkg::DRIVE_LO;
               end else begin
                  drive_in = total[fgpc_pkg::DRIVE_W-1:0];
               end
               p_in         = mul_res[0];
               i_in         = mul_res[1];
               d_in         = mul_res[2];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         esum_ff      <= '0;
         cfg_ff[fgpc_pkg::REG_ERROR_MAX]        <= fgpc_pkg::RST_ERROR_MAX;
         cfg_ff[fgpc_pkg::REG_ERROR_CHANGE_MAX] <= fgpc_pkg::RST_ERROR_CHANGE_MAX;
         cfg_ff[fgpc_pkg::REG_KP_WEIGHT]        <= fgpc_pkg::RST_KP_WEIGHT;
         cfg_ff[fgpc_pkg::REG_KI_WEIGHT]        <= fgpc_pkg::RST_KI_WEIGHT;
         cfg_ff[fgpc_pkg::REG_KD_WEIGHT]        <= fgpc_pkg::RST_KD_WEIGHT;
         cfg_ff[fgpc_pkg::REG_KP_BASE]          <= '0;
         cfg_ff[fgpc_pkg::REG_KI_BASE]          <= '0;
         cfg_ff[fgpc_pkg::REG_KD_BASE]          <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         last_err_ff  <= last_err_in;
         esum_ff      <= esum_in;
         if (csr_valid) begin
            cfg_ff[csr_index] <= csr_wdata[GW-1:0];
         end
      end
      t_ff     <= t_in;
      m_ff     <= m_in;
      err_ff   <= err_in;
      chg_ff   <= chg_in;
      ei_ff    <= ei_in;
      ci_ff    <= ci_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      gain_ff  <= gain_in;
      drive_ff <= drive_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      d_ff     <= d_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_drive  = drive_ff;
   assign rsp_p_term = p_ff;
   assign rsp_i_term = i_ff;
   assign rsp_d_term = d_ff;

   // The three multipliers start together and so must finish together.
   `FGPC_ASSERT_NOW(a_mul_lockstep, clock, reset, 1'b1, mul_done == 3'b000 || mul_done == 3'b111, "multipliers out of step")
   // Both fuzzy indices lie within the rule tables when they are used.
   `FGPC_ASSERT_NOW(a_idx_range, clock, reset, state_ff == S_GAIN1, ei_ff <= fgpc_pkg::IDX_HIGH && ci_ff <= fgpc_pkg::IDX_HIGH, "fuzzy index out of range")
   // An accepted request starts the error stage on the next cycle.
   `FGPC_ASSERT_NEXT(a_accept_start, clock, reset, req_valid && req_ready, state_ff == S_ERR, "request not started")
   // A presented drive always lies inside the clamp window.
   `FGPC_ASSERT_NOW(a_drive_range, clock, reset, rsp_valid_ff, drive_ff >= fgpc_pkg::DRIVE_LO && drive_ff <= fgpc_pkg::DRIVE_HI, "drive outside clamp window")

endmodule
